// ----- rtl/cts_pkg.sv -----
// Shared constants, register codes and divider handshake types for the time sensor.
`default_nettype none

package cts_pkg;

    localparam int TIME_BITS = 48;
    localparam int FRAC_BITS = 16;
    localparam int STEP_COUNT = TIME_BITS + FRAC_BITS;
    localparam int CNT_BITS = $clog2(STEP_COUNT);

    localparam int CFG_INDEX_BITS = 2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ENABLE = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_START = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_STOP = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_INTERVAL = 2'd3;

    localparam logic [FRAC_BITS:0] FRAC_ONE = {1'b1, {FRAC_BITS{1'b0}}};

    typedef logic [TIME_BITS-1:0] time_t;
    typedef logic [FRAC_BITS:0] frac_t;

    typedef struct packed {
        logic  start;
        time_t dividend;
        time_t divisor;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [FRAC_BITS-1:0] quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

// ----- rtl/cts_if.sv -----
// Channel interfaces: time samples in, sensor status items out.
`default_nettype none

interface cts_time_if;
    logic              valid;
    logic              ready;
    cts_pkg::time_t    global_time;

    modport source (output valid, output global_time, input ready);
    modport sink (input valid, input global_time, output ready);
endinterface

interface cts_status_if;
    logic              valid;
    logic              ready;
    logic              fraction_event;
    cts_pkg::frac_t    fraction;
    logic              active_event;
    logic              active_value;
    logic              active;

    modport source (
        output valid, output fraction_event, output fraction,
        output active_event, output active_value, output active,
        input ready
    );
    modport sink (
        input valid, input fraction_event, input fraction,
        input active_event, input active_value, input active,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/cts_div_unit.sv -----
// Shared compare-subtract unit: elapsed mod interval, then the Q0.16 fraction bits.
`default_nettype none

module cts_div_unit (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cts_pkg::div_req_t req,
    output cts_pkg::div_rsp_t      rsp
);

    localparam logic [cts_pkg::CNT_BITS-1:0] LAST_STEP =
        cts_pkg::CNT_BITS'(cts_pkg::STEP_COUNT - 1);
    localparam logic [cts_pkg::CNT_BITS-1:0] MOD_STEPS =
        cts_pkg::CNT_BITS'(cts_pkg::TIME_BITS);

    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;
    logic [cts_pkg::CNT_BITS-1:0]    cnt_reg, cnt_next;
    cts_pkg::time_t                  dvd_reg, dvd_next;
    cts_pkg::time_t                  dvs_reg, dvs_next;
    cts_pkg::time_t                  rem_reg, rem_next;
    logic [cts_pkg::FRAC_BITS-1:0]   quo_reg, quo_next;

    logic                            mod_phase;
    logic                            in_bit;
    logic [cts_pkg::TIME_BITS:0]     trial;
    logic [cts_pkg::TIME_BITS+1:0]   diff;
    logic                            fits;

    assign mod_phase = cnt_reg < MOD_STEPS;
    assign in_bit = mod_phase ? dvd_reg[cts_pkg::TIME_BITS-1] : 1'b0;
    assign trial = {rem_reg, in_bit};
    assign diff = {1'b0, trial} - {2'b00, dvs_reg};
    assign fits = !diff[cts_pkg::TIME_BITS+1];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next = cnt_reg;
        dvd_next = dvd_reg;
        dvs_next = dvs_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next = '0;
            dvd_next = req.dividend;
            dvs_next = req.divisor;
            rem_next = '0;
            quo_next = '0;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[cts_pkg::TIME_BITS-2:0], 1'b0};
            rem_next = fits ? diff[cts_pkg::TIME_BITS-1:0] : trial[cts_pkg::TIME_BITS-1:0];
            if (!mod_phase)
            begin
                quo_next = {quo_reg[cts_pkg::FRAC_BITS-2:0], fits};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

`default_nettype wire

// ----- rtl/cyclic_time_sensor.sv -----
// Top level of the cyclic time sensor: register file, sequencer and result register.
//
//   channel   direction  handshake        payload
//   sample    in         valid / ready    global_time[47:0]
//   status    out        valid / ready    fraction_event, fraction[16:0], active_event,
//                                         active_value, active
//   cfg       in         cfg_we           cfg_index[1:0], cfg_data[47:0]
//
// One item at a time: accept, an evaluate state, then 64 compare-subtract steps of the
// shared divider (48 for the remainder, 16 for the fraction) when the sensor is enabled
// and active and the interval is nonzero. Reset clears the config, state and status
// registers, the sensor inactive and the fraction 0; the captured sample time is not reset.
// A stalled status item holds in the result register; sample is not ready until it leaves.
`default_nettype none

module cyclic_time_sensor (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [cts_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [cts_pkg::TIME_BITS-1:0]       cfg_data,
    cts_time_if.sink                                 sample,
    cts_status_if.source                             status
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EVAL = 2'd1;
    localparam logic [1:0] ST_DIV = 2'd2;
    localparam logic [1:0] ST_OUT = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic              enable_reg;
    cts_pkg::time_t    start_reg;
    cts_pkg::time_t    stop_reg;
    cts_pkg::time_t    interval_reg;
    cts_pkg::time_t    time_reg;
    logic              active_reg, active_next;
    cts_pkg::frac_t    frac_reg, frac_next;
    logic              fev_reg, fev_next;
    logic              aev_reg, aev_next;
    logic              aval_reg, aval_next;

    logic              activate;
    logic              deactivate;
    cts_pkg::time_t    elapsed;
    cts_pkg::div_req_t div_req;
    cts_pkg::div_rsp_t div_rsp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            start_reg <= '0;
            stop_reg <= '0;
            interval_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                cts_pkg::CFG_ENABLE:   enable_reg <= cfg_data[0];
                cts_pkg::CFG_START:    start_reg <= cfg_data;
                cts_pkg::CFG_STOP:     stop_reg <= cfg_data;
                cts_pkg::CFG_INTERVAL: interval_reg <= cfg_data;
            endcase
        end
    end

    assign activate = !active_reg && (time_reg >= start_reg)
        && ((stop_reg <= start_reg) || (time_reg < stop_reg));
    assign deactivate = active_reg && (stop_reg > start_reg) && (time_reg >= stop_reg);
    assign elapsed = (time_reg >= start_reg) ? (time_reg - start_reg) : '0;

    always_comb
    begin
        state_next = state_reg;
        active_next = active_reg;
        frac_next = frac_reg;
        fev_next = fev_reg;
        aev_next = aev_reg;
        aval_next = aval_reg;
        div_req.start = 1'b0;
        div_req.dividend = elapsed;
        div_req.divisor = interval_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample.valid)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                fev_next = 1'b0;
                aev_next = 1'b0;
                aval_next = 1'b0;
                state_next = ST_OUT;
                if (enable_reg)
                begin
                    if (activate || (active_reg && !deactivate))
                    begin
                        active_next = 1'b1;
                        fev_next = 1'b1;
                        aev_next = activate;
                        aval_next = activate;
                        if (interval_reg != '0)
                        begin
                            div_req.start = 1'b1;
                            state_next = ST_DIV;
                        end
                    end
                    else if (deactivate)
                    begin
                        active_next = 1'b0;
                        frac_next = cts_pkg::FRAC_ONE;
                        aev_next = 1'b1;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    frac_next = {1'b0, div_rsp.quotient};
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (status.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            active_reg <= 1'b0;
            frac_reg <= '0;
            fev_reg <= 1'b0;
            aev_reg <= 1'b0;
            aval_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            active_reg <= active_next;
            frac_reg <= frac_next;
            fev_reg <= fev_next;
            aev_reg <= aev_next;
            aval_reg <= aval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample.valid && sample.ready)
        begin
            time_reg <= sample.global_time;
        end
    end

    cts_div_unit u_div (
        .clk (clk),
        .rst_n (rst_n),
        .req (div_req),
        .rsp (div_rsp)
    );

    assign sample.ready = (state_reg == ST_IDLE);
    assign status.valid = (state_reg == ST_OUT);
    assign status.fraction_event = fev_reg;
    assign status.fraction = frac_reg;
    assign status.active_event = aev_reg;
    assign status.active_value = aval_reg;
    assign status.active = active_reg;

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(sample.ready && status.valid))
        else $error("sample ready while a status item waits");

    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide state");

    a_accept_eval: assert property (@(posedge clk) disable iff (!rst_n)
        (sample.valid && sample.ready) |=> (state_reg == ST_EVAL))
        else $error("accepted item not evaluated");

    a_stop_full: assert property (@(posedge clk) disable iff (!rst_n)
        (status.valid && status.active_event && !status.active_value)
        |-> (status.fraction == cts_pkg::FRAC_ONE && !status.fraction_event
             && !status.active))
        else $error("deactivation item without full fraction");

endmodule

`default_nettype wire

// ----- bench/cts_status_check.sv -----
// Status checker for the cyclic time sensor: tracks config, predicts each item and compares.
`timescale 1ns / 1ps

module cts_status_check (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [cts_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [cts_pkg::TIME_BITS-1:0]       cfg_data,
    cts_time_if                                      sample,
    cts_status_if                                    status,
    output int                                       error_count,
    output int                                       pending_count,
    output int                                       checked_count
);

    typedef struct packed {
        logic           fraction_event;
        cts_pkg::frac_t fraction;
        logic           active_event;
        logic           active_value;
        logic           active;
    } sensor_status_t;

    logic           enabled;
    cts_pkg::time_t start_tick;
    cts_pkg::time_t stop_tick;
    cts_pkg::time_t cycle_len;
    logic           sensor_active;
    cts_pkg::frac_t sensor_fraction;

    sensor_status_t expected_status_q[$];
    sensor_status_t want;
    sensor_status_t got;

    function automatic sensor_status_t advance_sensor(input cts_pkg::time_t t);
        sensor_status_t s;
        logic           was_active;
        cts_pkg::time_t elapsed;
        logic [63:0]    scaled;
        logic [63:0]    quotient;
        s = '0;
        if (enabled)
        begin
            was_active = sensor_active;
            if (!sensor_active && t >= start_tick && (stop_tick <= start_tick || t < stop_tick))
            begin
                sensor_active = 1'b1;
            end
            else if (sensor_active && stop_tick > start_tick && t >= stop_tick)
            begin
                sensor_active = 1'b0;
                sensor_fraction = cts_pkg::FRAC_ONE;
                s.active_event = 1'b1;
            end
            if (sensor_active)
            begin
                elapsed = (t >= start_tick) ? t - start_tick : '0;
                if (cycle_len != '0)
                begin
                    scaled = 64'(elapsed % cycle_len) << cts_pkg::FRAC_BITS;
                    quotient = scaled / 64'(cycle_len);
                    sensor_fraction = quotient[cts_pkg::FRAC_BITS:0];
                end
                s.fraction_event = 1'b1;
                if (!was_active)
                begin
                    s.active_event = 1'b1;
                    s.active_value = 1'b1;
                end
            end
        end
        s.fraction = sensor_fraction;
        s.active = sensor_active;
        return s;
    endfunction

    task automatic flag_field(input string field, input cts_pkg::frac_t exp_v,
                              input cts_pkg::frac_t act_v);
        $display("%0t: status %s expected %0h, got %0h", $time, field, exp_v, act_v);
        error_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled = 1'b0;
            start_tick = '0;
            stop_tick = '0;
            cycle_len = '0;
            sensor_active = 1'b0;
            sensor_fraction = '0;
            expected_status_q.delete();
            error_count = 0;
            pending_count = 0;
            checked_count = 0;
        end
        else
        begin
            if (status.valid && status.ready)
            begin
                got.fraction_event = status.fraction_event;
                got.fraction = status.fraction;
                got.active_event = status.active_event;
                got.active_value = status.active_value;
                got.active = status.active;
                if (expected_status_q.size() == 0)
                begin
                    $display("%0t: status item with none expected, got %h", $time, got);
                    error_count++;
                end
                else
                begin
                    want = expected_status_q.pop_front();
                    checked_count++;
                    if (got.fraction_event !== want.fraction_event)
                        flag_field("fraction_event", cts_pkg::frac_t'(want.fraction_event),
                                   cts_pkg::frac_t'(got.fraction_event));
                    if (got.fraction !== want.fraction)
                        flag_field("fraction", want.fraction, got.fraction);
                    if (got.active_event !== want.active_event)
                        flag_field("active_event", cts_pkg::frac_t'(want.active_event),
                                   cts_pkg::frac_t'(got.active_event));
                    if (got.active_value !== want.active_value)
                        flag_field("active_value", cts_pkg::frac_t'(want.active_value),
                                   cts_pkg::frac_t'(got.active_value));
                    if (got.active !== want.active)
                        flag_field("active", cts_pkg::frac_t'(want.active),
                                   cts_pkg::frac_t'(got.active));
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    cts_pkg::CFG_ENABLE:   enabled = cfg_data[0];
                    cts_pkg::CFG_START:    start_tick = cfg_data;
                    cts_pkg::CFG_STOP:     stop_tick = cfg_data;
                    cts_pkg::CFG_INTERVAL: cycle_len = cfg_data;
                    default:               ;
                endcase
            end
            if (sample.valid && sample.ready)
                expected_status_q.push_back(advance_sensor(sample.global_time));
            pending_count = expected_status_q.size();
        end
    end

endmodule

// ----- bench/cyclic_time_sensor_test.sv -----
// Top of the cyclic time sensor bench: clock, reset, register settings and time stimulus.
`timescale 1ns / 1ps

module cyclic_time_sensor_test;

    localparam cts_pkg::time_t TIME_MAX = '1;

    logic                               clk = 1'b0;
    logic                               rst_n;
    logic                               cfg_we;
    logic [cts_pkg::CFG_INDEX_BITS-1:0] cfg_index;
    cts_pkg::time_t                     cfg_data;

    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int item_count = 0;
    int setting_count = 0;
    int error_count;
    int pending_count;
    int checked_count;

    cts_time_if   sample_ch ();
    cts_status_if status_ch ();

    cyclic_time_sensor dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (sample_ch),
        .status    (status_ch)
    );

    cts_status_check status_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .sample        (sample_ch),
        .status        (status_ch),
        .error_count   (error_count),
        .pending_count (pending_count),
        .checked_count (checked_count)
    );

    always #4 clk = ~clk;

    initial
    begin
        status_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            status_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    function automatic cts_pkg::time_t rand48();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[cts_pkg::TIME_BITS-1:0];
    endfunction

    task automatic send_time(input cts_pkg::time_t t);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sample_ch.valid <= 1'b1;
        sample_ch.global_time <= t;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        item_count++;
    endtask

    task automatic settle();
        sample_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_count != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_config(input logic en, input cts_pkg::time_t start_tick,
                              input cts_pkg::time_t stop_tick,
                              input cts_pkg::time_t cycle_len);
        settle();
        cfg_we <= 1'b1;
        cfg_index <= cts_pkg::CFG_ENABLE;
        cfg_data <= cts_pkg::time_t'(en);
        @(posedge clk);
        cfg_index <= cts_pkg::CFG_START;
        cfg_data <= start_tick;
        @(posedge clk);
        cfg_index <= cts_pkg::CFG_STOP;
        cfg_data <= stop_tick;
        @(posedge clk);
        cfg_index <= cts_pkg::CFG_INTERVAL;
        cfg_data <= cycle_len;
        @(posedge clk);
        cfg_we <= 1'b0;
        setting_count++;
    endtask

    task automatic run_segment();
        cts_pkg::time_t start_tick;
        cts_pkg::time_t stop_tick;
        cts_pkg::time_t cycle_len;
        cts_pkg::time_t span;
        cts_pkg::time_t cur;
        cts_pkg::time_t t;
        int             length;
        case ($urandom_range(3))
            0:
            begin
                start_tick = cts_pkg::time_t'($urandom_range(0, 1000));
                stop_tick = start_tick + cts_pkg::time_t'($urandom_range(1, 1000));
                cycle_len = cts_pkg::time_t'($urandom_range(0, 40));
            end
            1:
            begin
                start_tick = rand48();
                stop_tick = rand48();
                cycle_len = rand48() >> $urandom_range(0, 47);
            end
            2:
            begin
                start_tick = cts_pkg::time_t'($urandom_range(0, 500));
                stop_tick = cts_pkg::time_t'($urandom_range(0, 500));
                cycle_len = cts_pkg::time_t'($urandom_range(1, 300));
            end
            default:
            begin
                start_tick = rand48() | 48'hFFFF_0000_0000;
                stop_tick = start_tick + cts_pkg::time_t'($urandom_range(1, 100000));
                cycle_len = cts_pkg::time_t'($urandom_range(1, 5000)) << $urandom_range(0, 8);
            end
        endcase
        set_config($urandom_range(7) != 0, start_tick, stop_tick, cycle_len);
        span = (stop_tick > start_tick) ? stop_tick - start_tick : 48'd4000;
        cur = (start_tick > span / 4) ? start_tick - span / 4 : '0;
        length = $urandom_range(25, 60);
        repeat (length)
        begin
            case ($urandom_range(9))
                0: t = rand48();
                1: t = cur - cts_pkg::time_t'($urandom_range(0, 50));
                2:
                begin
                    cur = start_tick + cts_pkg::time_t'($urandom_range(0, 5));
                    t = cur;
                end
                default:
                begin
                    cur = cur + (span >> $urandom_range(3, 6))
                        + cts_pkg::time_t'($urandom_range(0, 3));
                    t = cur;
                end
            endcase
            send_time(t);
        end
    endtask

    initial
    begin
        int target;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= cts_pkg::CFG_ENABLE;
        cfg_data <= '0;
        sample_ch.valid <= 1'b0;
        sample_ch.global_time <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // disabled out of reset
        send_time(48'd123);

        set_config(1'b1, 48'd100, 48'd200, 48'd10);
        send_time(48'd50);
        send_time(48'd100);
        send_time(48'd105);
        send_time(48'd99);
        send_time(48'd199);
        send_time(48'd200);
        send_time(48'd250);
        send_time(48'd150);
        send_time(48'd300);

        // zero interval keeps the forced full fraction
        set_config(1'b1, 48'd10, 48'd5, 48'd0);
        send_time(48'd20);
        send_time(48'd0);

        set_config(1'b1, 48'd0, 48'd0, TIME_MAX);
        send_time(TIME_MAX);
        send_time(TIME_MAX - 1);
        send_time(48'hAAAA_AAAA_AAAA);
        send_time(48'h5555_5555_5555);

        set_config(1'b0, TIME_MAX, TIME_MAX, 48'd1);
        send_time(48'd7);

        set_config(1'b1, 48'd0, 48'd1, 48'd1);
        send_time(48'd5);

        set_config(1'b1, TIME_MAX, TIME_MAX, 48'd1);
        send_time(TIME_MAX - 1);
        send_time(TIME_MAX);

        set_config(1'b1, 48'd0, TIME_MAX, TIME_MAX);
        send_time(TIME_MAX - 1);
        send_time(TIME_MAX);

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    sender_idle_pct = 16;
                    receiver_stall_pct = 80;
                end
                1:
                begin
                    sender_idle_pct = 80;
                    receiver_stall_pct = 16;
                end
                default:
                begin
                    sender_idle_pct = 0;
                    receiver_stall_pct = 0;
                end
            endcase
            target = item_count + 250;
            while (item_count < target)
                run_segment();
        end

        settle();
        $display("Drove %0d time samples over %0d register settings in three idling phases.",
                 item_count, setting_count);
        $display("Compared %0d status items, %0d field mismatches.", checked_count, error_count);
        if (error_count == 0 && pending_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/cts_pkg.sv
rtl/cts_if.sv
rtl/cts_div_unit.sv
rtl/cyclic_time_sensor.sv
bench/cts_status_check.sv
bench/cyclic_time_sensor_test.sv
